// File: design/qrl_pkg.sv
// Shared types and codes of the quota reservation ledger.
`default_nettype none
package qrl_pkg;

    // request kinds carried in s_axis_tuser
    localparam logic [1:0] MODE_RESERVE  = 2'd0;
    localparam logic [1:0] MODE_RELEASE  = 2'd1;
    localparam logic [1:0] MODE_OVERRIDE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_JOBS   = 2'd0;
    localparam logic [1:0] CFG_MAX_SHARDS = 2'd1;
    localparam logic [1:0] CFG_MAX_MEMORY = 2'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_CONFLICT  = 3'd2,
        ST_EXCEEDED  = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    // jobs / shards / memory triple, used both for usage and for limits
    typedef struct packed {
        logic [52:0] memory;
        logic [21:0] shards;
        logic [6:0]  jobs;
    } t_amounts;

    // one reservation as recorded in the ledger
    typedef struct packed {
        logic [46:0] memory;
        logic [14:0] shards;
        logic [3:0]  project;
    } t_ledger_entry;

endpackage
`default_nettype wire

// File: design/qrl_ledger_ram.sv
// Reservation ledger storage: one write port, one registered read port.
`default_nettype none
module qrl_ledger_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire                         i_clk,
    input  wire                         i_rd_en,
    input  wire  [AW-1:0]               i_rd_addr,
    output qrl_pkg::t_ledger_entry      o_rd_data,
    input  wire                         i_wr_en,
    input  wire  [AW-1:0]               i_wr_addr,
    input  wire qrl_pkg::t_ledger_entry i_wr_data
);

    qrl_pkg::t_ledger_entry r_mem [DEPTH];
    qrl_pkg::t_ledger_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// File: design/qrl_accounts.sv
// Per-project usage counters and limit overrides.
`default_nettype none
module qrl_accounts #(
    parameter int NUM_PROJECTS = 16,
    parameter int PW           = 4
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire  [PW-1:0]          i_idx,
    input  wire                    i_usage_we,
    input  wire qrl_pkg::t_amounts i_usage,
    input  wire                    i_ovr_we,
    input  wire qrl_pkg::t_amounts i_ovr,
    output qrl_pkg::t_amounts      o_usage,
    output logic                   o_ovr_valid,
    output qrl_pkg::t_amounts      o_ovr
);

    qrl_pkg::t_amounts        r_usage [NUM_PROJECTS];
    qrl_pkg::t_amounts        r_ovr   [NUM_PROJECTS];
    logic [NUM_PROJECTS-1:0]  r_ovr_valid;

    // usage and override flags clear on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PROJECTS; k++) begin
                r_usage[k] <= '0;
            end
            r_ovr_valid <= '0;
        end else begin
            if (i_usage_we) begin
                r_usage[i_idx] <= i_usage;
            end
            if (i_ovr_we) begin
                r_ovr_valid[i_idx] <= 1'b1;
            end
        end
    end

    // override limits are only read behind their valid flag
    always_ff @(posedge i_clk) begin
        if (i_ovr_we) begin
            r_ovr[i_idx] <= i_ovr;
        end
    end

    assign o_usage     = r_usage[i_idx];
    assign o_ovr_valid = r_ovr_valid[i_idx];
    assign o_ovr       = r_ovr[i_idx];

endmodule
`default_nettype wire

// File: design/quota_reservation_ledger.sv
// Quota reservation ledger: admission control for per-project resource quotas.
//
// Each request beat (reserve, release or set-override, selected by s_axis_tuser)
// is registered, the ledger entry for its job slot is read from a RAM in the
// same cycle, and once the result register can take it, one pass of compare/add
// logic decides the status, updates usage, ledger and overrides, and loads the
// result register. The block takes one request every cycle while the result
// side does not stall; the rate is set by that single read-modify-write pass
// over the project counters and the ledger RAM, with a bypass of the ledger
// write into a read issued in the same cycle. A reserve is checked for invalid
// dimensions, then for a held slot (identical request is a replay: ok, no
// charge; anything else is a conflict), then against the job, shard and memory
// limits (inclusive); the limits come from the project's override when one has
// been set, else from the default registers. A release frees the slot and
// subtracts its recorded amounts from the recorded project, clamping at zero.
// Every result reports the usage of the project concerned after the step and
// whether the job slot is held. The default registers reset to zero, so every reserve
// without an override is refused until they are written; write them only while idle.
`default_nettype none
module quota_reservation_ledger #(
    parameter int NUM_PROJECTS  = 16,
    parameter int NUM_JOB_SLOTS = 64
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    // request: project[3:0], job[9:4], shards[25:10], req_memory[73:26],
    // limit_jobs[80:74], limit_shards[102:81], limit_memory[155:103], zero pad
    input  wire           s_axis_tvalid,
    output logic          s_axis_tready,
    input  wire  [159:0]  s_axis_tdata,
    // request kind: mode[1:0]
    input  wire  [1:0]    s_axis_tuser,
    // result: status[2:0], job_held[3], used_jobs[10:4], used_shards[32:11],
    // used_memory[85:33], zero pad
    output logic          m_axis_tvalid,
    input  wire           m_axis_tready,
    output logic [87:0]   m_axis_tdata,
    // configuration write
    input  wire           i_cfg_we,
    input  wire  [1:0]    i_cfg_index,
    input  wire  [52:0]   i_cfg_wdata
);

    localparam int PW  = (NUM_PROJECTS  > 1) ? $clog2(NUM_PROJECTS)  : 1;
    localparam int JW  = (NUM_JOB_SLOTS > 1) ? $clog2(NUM_JOB_SLOTS) : 1;
    localparam int PXW = (PW > 4) ? PW : 4;
    localparam int JXW = (JW > 6) ? JW : 6;

    // ---------------- configuration ----------------
    qrl_pkg::t_amounts r_def;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == qrl_pkg::CFG_MAX_JOBS) begin
                r_def.jobs <= i_cfg_wdata[6:0];
            end
            if (i_cfg_index == qrl_pkg::CFG_MAX_SHARDS) begin
                r_def.shards <= i_cfg_wdata[21:0];
            end
            if (i_cfg_index == qrl_pkg::CFG_MAX_MEMORY) begin
                r_def.memory <= i_cfg_wdata;
            end
        end
    end

    // ---------------- handshake ----------------
    logic r_in_valid;
    logic r_out_valid;
    logic fire;      // registered request is decided and committed this cycle
    logic in_accept;

    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // ---------------- request register ----------------
    logic [1:0]  r_mode;
    logic [3:0]  r_project;
    logic [5:0]  r_job;
    logic [15:0] r_shards;
    logic [47:0] r_mem;
    qrl_pkg::t_amounts r_lim_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode          <= s_axis_tuser;
            r_project       <= s_axis_tdata[3:0];
            r_job           <= s_axis_tdata[9:4];
            r_shards        <= s_axis_tdata[25:10];
            r_mem           <= s_axis_tdata[73:26];
            r_lim_in.jobs   <= s_axis_tdata[80:74];
            r_lim_in.shards <= s_axis_tdata[102:81];
            r_lim_in.memory <= s_axis_tdata[155:103];
        end
    end

    // ---------------- ledger RAM with write bypass ----------------
    logic [JXW-1:0] in_job_ext;
    logic [JW-1:0]  rd_addr;
    logic [JXW-1:0] job_ext;
    logic [JW-1:0]  j_idx;
    logic           led_we;
    qrl_pkg::t_ledger_entry led_wdata;
    qrl_pkg::t_ledger_entry ram_rdata;
    qrl_pkg::t_ledger_entry r_fwd_data;
    logic                   r_fwd;
    qrl_pkg::t_ledger_entry led;

    assign in_job_ext = JXW'(s_axis_tdata[9:4]);
    assign rd_addr    = in_job_ext[JW-1:0];
    assign job_ext    = JXW'(r_job);
    assign j_idx      = job_ext[JW-1:0];

    qrl_ledger_ram #(
        .DEPTH (NUM_JOB_SLOTS),
        .AW    (JW)
    ) u_ledger (
        .i_clk     (i_clk),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rdata),
        .i_wr_en   (led_we),
        .i_wr_addr (j_idx),
        .i_wr_data (led_wdata)
    );

    // catch a ledger write landing in the slot being read at the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (in_accept) begin
            r_fwd <= led_we && (j_idx == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_fwd_data <= led_wdata;
        end
    end

    assign led = r_fwd ? r_fwd_data : ram_rdata;

    // slot occupancy flags
    logic [NUM_JOB_SLOTS-1:0] r_led_valid;
    logic set_valid;
    logic clr_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_valid <= '0;
        end else if (set_valid) begin
            r_led_valid[j_idx] <= 1'b1;
        end else if (clr_valid) begin
            r_led_valid[j_idx] <= 1'b0;
        end
    end

    // ---------------- decision ----------------
    logic           p_ok;
    logic           j_ok;
    logic           held;
    logic           rel_ok;
    logic [3:0]     u_sel;
    logic           u_ok;
    logic [PXW-1:0] u_ext;
    logic [PW-1:0]  u_idx;

    assign p_ok   = {28'd0, r_project} < 32'(NUM_PROJECTS);
    assign j_ok   = {26'd0, r_job} < 32'(NUM_JOB_SLOTS);
    assign held   = j_ok && r_led_valid[j_idx];
    // a successful release concerns the project recorded in the ledger
    assign rel_ok = (r_mode == qrl_pkg::MODE_RELEASE) && held;
    assign u_sel  = rel_ok ? led.project : r_project;
    assign u_ok   = {28'd0, u_sel} < 32'(NUM_PROJECTS);
    assign u_ext  = PXW'(u_sel);
    assign u_idx  = u_ext[PW-1:0];

    qrl_pkg::t_amounts cur;
    qrl_pkg::t_amounts ovr;
    qrl_pkg::t_amounts lim;
    qrl_pkg::t_amounts new_usage;
    logic              ovr_valid;
    logic              usage_we;
    logic              ovr_we;

    qrl_accounts #(
        .NUM_PROJECTS (NUM_PROJECTS),
        .PW           (PW)
    ) u_accounts (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_idx       (u_idx),
        .i_usage_we  (usage_we),
        .i_usage     (new_usage),
        .i_ovr_we    (ovr_we),
        .i_ovr       (r_lim_in),
        .o_usage     (cur),
        .o_ovr_valid (ovr_valid),
        .o_ovr       (ovr)
    );

    assign lim = ovr_valid ? ovr : r_def;

    logic [7:0]  sum_jobs;
    logic [22:0] sum_shards;
    logic [53:0] sum_mem;
    logic        over;
    logic        bad_dim;
    logic        replay;

    assign sum_jobs   = {1'b0, cur.jobs} + 8'd1;
    assign sum_shards = {1'b0, cur.shards} + 23'(r_shards[14:0]);
    assign sum_mem    = {1'b0, cur.memory} + 54'(r_mem[46:0]);
    assign over       = (sum_jobs   > {1'b0, lim.jobs})
                     || (sum_shards > {1'b0, lim.shards})
                     || (sum_mem    > {1'b0, lim.memory});
    assign bad_dim    = (r_shards == 16'd0) || r_shards[15] || r_mem[47];
    assign replay     = (led.project == r_project)
                     && ({1'b0, led.shards} == r_shards)
                     && ({1'b0, led.memory} == r_mem);

    assign led_wdata.project = r_project;
    assign led_wdata.shards  = r_shards[14:0];
    assign led_wdata.memory  = r_mem[46:0];

    qrl_pkg::t_status status;
    logic             held_after;
    logic             do_usage;
    logic             do_led;
    logic             do_set;
    logic             do_clr;
    logic             do_ovr;

    always_comb begin
        status     = qrl_pkg::ST_INVALID;
        held_after = held;
        new_usage  = cur;
        do_usage   = 1'b0;
        do_led     = 1'b0;
        do_set     = 1'b0;
        do_clr     = 1'b0;
        do_ovr     = 1'b0;
        unique case (r_mode)
            qrl_pkg::MODE_RESERVE: begin
                if (!(p_ok && j_ok) || bad_dim) begin
                    status = qrl_pkg::ST_INVALID;
                end else if (held) begin
                    status = replay ? qrl_pkg::ST_OK : qrl_pkg::ST_CONFLICT;
                end else if (over) begin
                    status = qrl_pkg::ST_EXCEEDED;
                end else begin
                    status           = qrl_pkg::ST_OK;
                    new_usage.jobs   = sum_jobs[6:0];
                    new_usage.shards = sum_shards[21:0];
                    new_usage.memory = sum_mem[52:0];
                    do_usage         = 1'b1;
                    do_led           = 1'b1;
                    do_set           = 1'b1;
                    held_after       = 1'b1;
                end
            end
            qrl_pkg::MODE_RELEASE: begin
                if (!j_ok) begin
                    status = qrl_pkg::ST_INVALID;
                end else if (!held) begin
                    status = qrl_pkg::ST_NOT_FOUND;
                end else begin
                    status     = qrl_pkg::ST_OK;
                    do_clr     = 1'b1;
                    held_after = 1'b0;
                    // subtract what the slot recorded, clamp each counter at zero
                    new_usage.jobs   = (cur.jobs != 7'd0) ? cur.jobs - 7'd1 : 7'd0;
                    new_usage.shards = (cur.shards >= 22'(led.shards))
                                     ? cur.shards - 22'(led.shards) : 22'd0;
                    new_usage.memory = (cur.memory >= 53'(led.memory))
                                     ? cur.memory - 53'(led.memory) : 53'd0;
                    do_usage         = u_ok;
                end
            end
            qrl_pkg::MODE_OVERRIDE: begin
                if (p_ok) begin
                    status = qrl_pkg::ST_OK;
                    do_ovr = 1'b1;
                end
            end
            default: begin
                status = qrl_pkg::ST_INVALID;
            end
        endcase
    end

    assign usage_we  = fire && do_usage;
    assign led_we    = fire && do_led;
    assign set_valid = fire && do_set;
    assign clr_valid = fire && do_clr;
    assign ovr_we    = fire && do_ovr;

    // ---------------- result register ----------------
    qrl_pkg::t_status  r_status;
    logic              r_held;
    qrl_pkg::t_amounts r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status <= status;
            r_held   <= held_after;
            // a project beyond the table reports zero usage
            r_used   <= u_ok ? new_usage : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_used.memory, r_used.shards, r_used.jobs,
                            r_held, r_status};

endmodule
`default_nettype wire

// File: dv/tb_quota_reservation_ledger.sv
`timescale 1ns / 100ps
// Self-checking testbench of the quota reservation ledger: directed and random request beats.
module tb_quota_reservation_ledger;

    // mode three has no meaning; the block must flag it as invalid
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // one request as it travels on the slave side, limits packed as in tdata
    typedef struct packed {
        logic [1:0]        mode;
        logic [3:0]        project;
        logic [5:0]        job;
        logic [15:0]       shards;
        logic [47:0]       memory;
        qrl_pkg::t_amounts limits;
    } t_request;

    // one admission decision as it should come back on the master side
    typedef struct packed {
        qrl_pkg::t_status  status;
        logic              held;
        qrl_pkg::t_amounts usage;
    } t_outcome;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [159:0]  s_axis_tdata;
    logic [1:0]    s_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [87:0]   m_axis_tdata;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_index;
    logic [52:0]   i_cfg_wdata;

    // predicted ledger contents, kept in step with every accepted request beat
    qrl_pkg::t_amounts      limit_default;
    qrl_pkg::t_amounts      usage_of [16];
    logic                   override_on [16];
    qrl_pkg::t_amounts      override_of [16];
    logic                   slot_held [64];
    qrl_pkg::t_ledger_entry slot_entry [64];

    // decisions still owed by the block, oldest first
    t_outcome      pending [$];

    int            mismatches;
    int            results_seen;
    int            gapless_left;
    int            stallfree_left;

    quota_reservation_ledger i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Admission decision for one accepted request; update the predicted state.
    function automatic t_outcome admit(input t_request r);
        t_outcome               res;
        qrl_pkg::t_amounts      lim;
        qrl_pkg::t_ledger_entry ent;
        logic [3:0]             owner;
        owner      = r.project;
        res.status = qrl_pkg::ST_OK;
        ent        = slot_entry[r.job];
        case (r.mode)
            qrl_pkg::MODE_RESERVE: begin
                lim = override_on[r.project] ? override_of[r.project] : limit_default;
                if (r.shards == 16'd0 || r.shards[15] || r.memory[47]) begin
                    res.status = qrl_pkg::ST_INVALID;
                end else if (slot_held[r.job]) begin
                    // identical request is a replay: ok, nothing charged
                    if (ent.project == r.project && ent.shards == r.shards[14:0] &&
                        ent.memory == r.memory[46:0])
                        res.status = qrl_pkg::ST_OK;
                    else
                        res.status = qrl_pkg::ST_CONFLICT;
                end else if (usage_of[r.project].jobs + 64'd1 > lim.jobs ||
                             usage_of[r.project].shards + r.shards[14:0] + 64'd0 >
                             lim.shards ||
                             usage_of[r.project].memory + r.memory[46:0] + 64'd0 >
                             lim.memory) begin
                    res.status = qrl_pkg::ST_EXCEEDED;
                end else begin
                    usage_of[r.project].jobs   = usage_of[r.project].jobs + 7'd1;
                    usage_of[r.project].shards = usage_of[r.project].shards + r.shards[14:0];
                    usage_of[r.project].memory = usage_of[r.project].memory + r.memory[46:0];
                    slot_held[r.job]  = 1'b1;
                    slot_entry[r.job] = {r.memory[46:0], r.shards[14:0], r.project};
                end
            end
            qrl_pkg::MODE_RELEASE: begin
                if (!slot_held[r.job]) begin
                    res.status = qrl_pkg::ST_NOT_FOUND;
                end else begin
                    // credit the project recorded in the slot, clamp each counter at zero
                    owner = ent.project;
                    usage_of[owner].jobs = (usage_of[owner].jobs >= 7'd1) ?
                                           usage_of[owner].jobs - 7'd1 : '0;
                    usage_of[owner].shards = (usage_of[owner].shards >= ent.shards) ?
                                             usage_of[owner].shards - ent.shards : '0;
                    usage_of[owner].memory = (usage_of[owner].memory >= ent.memory) ?
                                             usage_of[owner].memory - ent.memory : '0;
                    slot_held[r.job] = 1'b0;
                end
            end
            qrl_pkg::MODE_OVERRIDE: begin
                override_on[r.project] = 1'b1;
                override_of[r.project] = r.limits;
            end
            default: res.status = qrl_pkg::ST_INVALID;
        endcase
        res.held  = slot_held[r.job];
        res.usage = usage_of[owner];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("tb: mismatch in %s on result %0d: got 0x%0h, expected 0x%0h",
                 what, results_seen, got, want);
    endtask

    // Drive one request beat, hold it until accepted, then log its expected decision.
    task automatic send_request(input t_request r);
        int gap;
        if (gapless_left > 0) begin
            gapless_left--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 15);
            if ($urandom_range(0, 19) == 0)
                gapless_left = $urandom_range(10, 40);
        end
        // lower tvalid only when a gap follows, so back-to-back beats keep it high
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, r.limits, r.memory, r.shards, r.job, r.project};
        s_axis_tuser  <= r.mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending.push_back(admit(r));
    endtask

    // Drop tvalid and hold until every owed decision has come back.
    task automatic wait_idle(input int extra);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // Write all three default limit registers on consecutive edges while idle.
    task automatic set_defaults(input qrl_pkg::t_amounts lim);
        wait_idle(4);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= qrl_pkg::CFG_MAX_JOBS;
        i_cfg_wdata <= {46'd0, lim.jobs};
        @(posedge i_clk);
        i_cfg_index <= qrl_pkg::CFG_MAX_SHARDS;
        i_cfg_wdata <= {31'd0, lim.shards};
        @(posedge i_clk);
        i_cfg_index <= qrl_pkg::CFG_MAX_MEMORY;
        i_cfg_wdata <= lim.memory;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        limit_default  = lim;
        @(posedge i_clk);
    endtask

    function automatic t_request build_request(input logic [1:0] mode,
                                               input logic [3:0] project,
                                               input logic [5:0] job,
                                               input logic [15:0] shards,
                                               input logic [47:0] memory,
                                               input qrl_pkg::t_amounts limits);
        t_request r;
        r.mode    = mode;
        r.project = project;
        r.job     = job;
        r.shards  = shards;
        r.memory  = memory;
        r.limits  = limits;
        return r;
    endfunction

    // Spread limits from tight to generous so both admissions and refusals occur.
    function automatic qrl_pkg::t_amounts random_limits();
        qrl_pkg::t_amounts lim;
        logic [63:0]       w;
        if ($urandom_range(0, 1) == 0)
            lim.jobs = 7'($urandom_range(0, 8));
        else
            lim.jobs = 7'($urandom_range(0, 64));
        w          = {$urandom, $urandom};
        lim.shards = w[21:0] >> $urandom_range(0, 8);
        w          = {$urandom, $urandom};
        lim.memory = w[52:0] >> $urandom_range(0, 12);
        return lim;
    endfunction

    function automatic logic [47:0] random_memory();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       return 48'd0;
            1:       return {32'd0, w[15:0]};
            2:       return {16'd0, w[31:0]};
            default: return {1'b0, w[46:0]};
        endcase
    endfunction

    // Random job slot whose held state matches, or -1 if there is none.
    function automatic int find_slot(input logic held_state);
        int start;
        start = $urandom_range(0, 63);
        for (int k = 0; k < 64; k++) begin
            if (slot_held[(start + k) % 64] == held_state)
                return (start + k) % 64;
        end
        return -1;
    endfunction

    // Mostly well-formed reserve/release traffic, with replays, broken requests and noise.
    function automatic t_request random_request();
        t_request r;
        int       pick;
        int       slot;
        r.mode    = qrl_pkg::MODE_RESERVE;
        r.project = 4'($urandom_range(0, 15));
        r.job     = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 1) == 0)
            r.shards = 16'($urandom_range(1, 32767));
        else
            r.shards = 16'($urandom_range(1, 2000));
        r.memory = random_memory();
        r.limits = random_limits();
        pick     = $urandom_range(0, 99);
        if (pick < 48) begin
            // fresh reserve, usually into a free slot
            slot = find_slot(1'b0);
            if (slot >= 0 && $urandom_range(0, 9) < 7)
                r.job = 6'(slot);
        end else if (pick < 56) begin
            // replay an existing reservation exactly
            slot = find_slot(1'b1);
            if (slot >= 0) begin
                r.job     = 6'(slot);
                r.project = slot_entry[slot].project;
                r.shards  = {1'b0, slot_entry[slot].shards};
                r.memory  = {1'b0, slot_entry[slot].memory};
            end
        end else if (pick < 84) begin
            r.mode = qrl_pkg::MODE_RELEASE;
            slot   = find_slot(1'b1);
            if (slot >= 0 && $urandom_range(0, 4) != 0)
                r.job = 6'(slot);
        end else if (pick < 94) begin
            // broken dimensions
            case ($urandom_range(0, 2))
                0:       r.shards     = 16'd0;
                1:       r.shards[15] = 1'b1;
                default: r.memory[47] = 1'b1;
            endcase
        end else if (pick < 97) begin
            // overrides only on the upper projects, so the lower ones keep the defaults
            r.mode    = qrl_pkg::MODE_OVERRIDE;
            r.project = 4'($urandom_range(8, 15));
        end else begin
            r.mode = MODE_UNUSED;
        end
        return r;
    endfunction

    task automatic run_traffic(input int count);
        for (int n = 0; n < count; n++) begin
            // now and then hold off until the block has caught up completely
            if (n % 90 == 89)
                wait_idle(0);
            send_request(random_request());
        end
    endtask

    // Defaults reset to zero: the first reserve must be refused.
    task automatic test_reset_refusal();
        send_request(build_request(qrl_pkg::MODE_RESERVE, 4'd0, 6'd0, 16'd1, 48'd0, '0));
        send_request(build_request(qrl_pkg::MODE_RELEASE, 4'd0, 6'd0, 16'd1, 48'd0, '0));
    endtask

    task automatic test_directed_cases();
        set_defaults({53'd1000, 22'd100, 7'd2});
        send_request(build_request(qrl_pkg::MODE_RESERVE, 4'd0, 6'd0, 16'd10, 48'd100, '0));
        // replay, then two conflicts on the same slot
        send_request(build_request(qrl_pkg::MODE_RESERVE, 4'd0, 6'd0, 16'd10, 48'd100, '0));
        send_request(build_request(qrl_pkg::MODE_RESERVE, 4'd0, 6'd0, 16'd11, 48'd100, '0));
        send_request(build_request(qrl_pkg::MODE_RESERVE, 4'd1, 6'd0, 16'd10, 48'd100, '0));
        // invalid dimensions
        send_request(build_request(qrl_pkg::MODE_RESERVE, 4'd0, 6'd7, 16'd0, 48'd1, '0));
        send_request(build_request(qrl_pkg::MODE_RESERVE, 4'd0, 6'd7, 16'hFFFF, 48'd1, '0));
        send_request(build_request(qrl_pkg::MODE_RESERVE, 4'd0, 6'd7, 16'h8000, 48'd1, '0));
        send_request(build_request(qrl_pkg::MODE_RESERVE, 4'd0, 6'd7, 16'd1,
                                   48'h8000_0000_0000, '0));
        send_request(build_request(qrl_pkg::MODE_RESERVE, 4'd0, 6'd7, 16'd1,
                                   48'hFFFF_FFFF_FFFF, '0));
        // fill shards and memory exactly to the limit, then trip each limit
        send_request(build_request(qrl_pkg::MODE_RESERVE, 4'd0, 6'd1, 16'd90, 48'd900, '0));
        send_request(build_request(qrl_pkg::MODE_RESERVE, 4'd0, 6'd2, 16'd1, 48'd0, '0));
        send_request(build_request(qrl_pkg::MODE_RELEASE, 4'd0, 6'd1, 16'd0, 48'd0, '0));
        send_request(build_request(qrl_pkg::MODE_RESERVE, 4'd0, 6'd2, 16'd91, 48'd0, '0));
        send_request(build_request(qrl_pkg::MODE_RESERVE, 4'd0, 6'd2, 16'd1, 48'd901, '0));
        send_request(build_request(qrl_pkg::MODE_RELEASE, 4'd0, 6'd5, 16'd0, 48'd0, '0));
        // widest override and the largest legal request against it
        send_request(build_request(qrl_pkg::MODE_OVERRIDE, 4'd12, 6'd3, 16'd0, 48'd0,
                                   {53'h1F_FFFF_FFFF_FFFF, 22'h3F_FFFF, 7'd64}));
        send_request(build_request(qrl_pkg::MODE_RESERVE, 4'd12, 6'd3, 16'h7FFF,
                                   48'h7FFF_FFFF_FFFF, '0));
        // zero override refuses everything
        send_request(build_request(qrl_pkg::MODE_OVERRIDE, 4'd13, 6'd3, 16'd0, 48'd0, '0));
        send_request(build_request(qrl_pkg::MODE_RESERVE, 4'd13, 6'd4, 16'd1, 48'd0, '0));
        send_request(build_request(MODE_UNUSED, 4'd12, 6'd3, 16'd5, 48'd5, '0));
        send_request(build_request(qrl_pkg::MODE_RELEASE, 4'd0, 6'd3, 16'd0, 48'd0, '0));
        send_request(build_request(qrl_pkg::MODE_RELEASE, 4'd9, 6'd0, 16'd0, 48'd0, '0));
        send_request(build_request(qrl_pkg::MODE_RESERVE, 4'd15, 6'd63, 16'd1, 48'd0, '0));
        send_request(build_request(qrl_pkg::MODE_RELEASE, 4'd15, 6'd63, 16'd0, 48'd0, '0));
    endtask

    task automatic test_random_defaults();
        set_defaults(random_limits());
        run_traffic(310);
    endtask

    task automatic test_limit_extremes();
        set_defaults({53'h1F_FFFF_FFFF_FFFF, 22'h3F_FFFF, 7'd64});
        run_traffic(310);
        set_defaults('0);
        run_traffic(200);
    endtask

    task automatic test_tight_limits();
        set_defaults({53'd1048576, 22'd50, 7'd1});
        run_traffic(310);
    endtask

    // Accept result beats with random stalls and check each against the oldest expectation.
    initial begin : result_monitor
        t_outcome want;
        int       stall;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (stallfree_left > 0) begin
                stallfree_left--;
                stall = 0;
            end else begin
                stall = $urandom_range(0, 15);
                if ($urandom_range(0, 19) == 0)
                    stallfree_left = $urandom_range(10, 40);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            results_seen++;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[63:0], 64'd0);
            end else begin
                want = pending.pop_front();
                if (m_axis_tdata[2:0] !== want.status)
                    report_mismatch("status", 64'(m_axis_tdata[2:0]), 64'(want.status));
                if (m_axis_tdata[3] !== want.held)
                    report_mismatch("job_held", 64'(m_axis_tdata[3]), 64'(want.held));
                if (m_axis_tdata[10:4] !== want.usage.jobs)
                    report_mismatch("used_jobs", 64'(m_axis_tdata[10:4]),
                                    64'(want.usage.jobs));
                if (m_axis_tdata[32:11] !== want.usage.shards)
                    report_mismatch("used_shards", 64'(m_axis_tdata[32:11]),
                                    64'(want.usage.shards));
                if (m_axis_tdata[85:33] !== want.usage.memory)
                    report_mismatch("used_memory", 64'(m_axis_tdata[85:33]),
                                    64'(want.usage.memory));
            end
        end
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= qrl_pkg::MODE_RESERVE;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= qrl_pkg::CFG_MAX_JOBS;
        i_cfg_wdata   <= '0;
        mismatches     = 0;
        results_seen   = 0;
        gapless_left   = 0;
        stallfree_left = 0;
        limit_default  = '0;
        for (int p = 0; p < 16; p++) begin
            usage_of[p]    = '0;
            override_on[p] = 1'b0;
            override_of[p] = '0;
        end
        for (int j = 0; j < 64; j++) begin
            slot_held[j]  = 1'b0;
            slot_entry[j] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_refusal();
        test_directed_cases();
        test_random_defaults();
        test_limit_extremes();
        test_tight_limits();

        wait_idle(8);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
